>>> rtl/core/stsum_pkg.sv
// Package with the shared types, constants and state codes of the summation tree.
package stsum_pkg;

	localparam int MAX_POSITIONS_DEF = 4096;
	localparam int SIZE_W = 13;
	localparam int POS_W = 13;
	localparam int DATA_W = 32;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;

	localparam logic CMD_ADD = 1'b0;
	localparam logic CMD_SUM = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_QUERY
	} state_t;

	typedef struct packed {
		logic cmd;
		logic [POS_W-1:0] position_a;
		logic signed [DATA_W-1:0] value_b;
	} cmd_item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] range_sum;
		logic range_error;
	} result_item_t;

endpackage

>>> rtl/core/segment_tree_point_add_range_sum_top.sv
// Top level of the point-add, range-sum tree with its size register.
//
// Channel   Direction  Handshake                 Payload
// command   in         start high, busy low      cmd_item_t
// result    out        result_valid, one cycle   result_item_t
// cfg       in         cfg_valid and cfg_ready   size_in_use
//
// An add walks from its leaf up to the root, one tree level a cycle through the single
// read port and the shared adder.
// A range sum reads each node that it adds and then moves its bounds up a level;
// an empty or out-of-range query is answered from the idle state without a walk.
// After reset a clearing pass zeroes every entry of the store with busy high.
// The receiver cannot stall; each result is shown for exactly one cycle.
module segment_tree_point_add_range_sum_top #(
	parameter int MAX_POSITIONS = stsum_pkg::MAX_POSITIONS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  stsum_pkg::cmd_item_t         command,
	output logic                         result_valid,
	output stsum_pkg::result_item_t      result,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [stsum_pkg::SIZE_W-1:0] cfg_data
);

	import stsum_pkg::*;

	localparam int DEPTH = 2 * MAX_POSITIONS;
	localparam int AW = $clog2(DEPTH);
	localparam int CW = ($clog2(DEPTH + 1) > SIZE_W) ? $clog2(DEPTH + 1) : SIZE_W;

	logic [SIZE_W-1:0] size_q;
	logic [CW-1:0] size_ext, eff_size;
	logic ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			size_q <= cfg_data;
		end
	end

	assign size_ext = CW'(size_q);
	assign eff_size = (size_ext > CW'(MAX_POSITIONS)) ? CW'(MAX_POSITIONS) : size_ext;

	stsum_ctrl #(
		.MAX_POSITIONS(MAX_POSITIONS),
		.DEPTH(DEPTH),
		.AW(AW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.eff_size(eff_size),
		.result_valid(result_valid),
		.result(result),
		.ram_we(ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr),
		.ram_rdata(ram_rdata)
	);

	stsum_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

endmodule

>>> rtl/core/stsum_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stsum_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/core/stsum_ctrl.sv
// Sequencer and shared adder that walk the tree for clears, adds and range sums.
module stsum_ctrl #(
	parameter int MAX_POSITIONS = stsum_pkg::MAX_POSITIONS_DEF,
	parameter int DEPTH = 2 * MAX_POSITIONS,
	parameter int AW = $clog2(DEPTH),
	parameter int CW = ($clog2(DEPTH + 1) > stsum_pkg::SIZE_W) ?
		$clog2(DEPTH + 1) : stsum_pkg::SIZE_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  stsum_pkg::cmd_item_t         command,
	input  logic [CW-1:0]                eff_size,
	output logic                         result_valid,
	output stsum_pkg::result_item_t      result,
	output logic                         ram_we,
	output logic [AW-1:0]                ram_waddr,
	output logic [stsum_pkg::DATA_W-1:0] ram_wdata,
	output logic [AW-1:0]                ram_raddr,
	input  logic [stsum_pkg::DATA_W-1:0] ram_rdata
);

	import stsum_pkg::*;

	localparam int NW = $clog2(DEPTH + 1);

	state_t state_q, state_d;
	logic [AW-1:0] clr_q, clr_d;
	logic pend_q, pend_d;
	logic [NW-1:0] idx_q, idx_d;
	logic [NW-1:0] r_q, r_d;
	logic [DATA_W-1:0] acc_q, acc_d;
	logic [DATA_W-1:0] delta_q, delta_d;
	result_item_t result_q, result_d;
	logic result_valid_q, result_valid_d;

	logic [DATA_W-1:0] op_a, op_b, sum;
	logic [CW-1:0] pos_ext;
	logic add_ok, a_gt_b, b_gt_size, q_err;
	logic [NW-1:0] leaf, r_init, parent, r_dec, l_sh, r_sh;

	assign op_a = (state_q == ST_ADD) ? delta_q : acc_q;
	assign op_b = pend_q ? ram_rdata : '0;
	assign sum = op_a + op_b;

	assign pos_ext = CW'(command.position_a);
	assign add_ok = (command.position_a != '0) && (pos_ext <= eff_size);
	assign a_gt_b = command.value_b[DATA_W-1] ||
		(DATA_W'(command.position_a) > $unsigned(command.value_b));
	assign b_gt_size = !command.value_b[DATA_W-1] &&
		($unsigned(command.value_b) > DATA_W'(eff_size));
	assign q_err = (command.position_a == '0) || b_gt_size;
	assign leaf = NW'(MAX_POSITIONS) + NW'(command.position_a) - NW'(1);
	assign r_init = NW'(MAX_POSITIONS) + NW'($unsigned(command.value_b));
	assign parent = idx_q >> 1;
	assign r_dec = r_q - NW'(1);
	assign l_sh = idx_q >> 1;
	assign r_sh = r_q >> 1;

	always_comb begin
		state_d = state_q;
		clr_d = clr_q;
		pend_d = 1'b0;
		idx_d = idx_q;
		r_d = r_q;
		acc_d = acc_q;
		delta_d = delta_q;
		result_d = result_q;
		result_valid_d = 1'b0;
		ram_we = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = sum;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d = clr_q + AW'(1);
				if (clr_q == AW'(DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (command.cmd == CMD_ADD) begin
						if (add_ok) begin
							ram_raddr = leaf[AW-1:0];
							pend_d = 1'b1;
							idx_d = leaf;
							delta_d = command.value_b;
							state_d = ST_ADD;
						end
					end else if (a_gt_b) begin
						result_d.range_sum = '0;
						result_d.range_error = 1'b0;
						result_valid_d = 1'b1;
					end else if (q_err) begin
						result_d.range_sum = '0;
						result_d.range_error = 1'b1;
						result_valid_d = 1'b1;
					end else begin
						idx_d = leaf;
						r_d = r_init;
						acc_d = '0;
						state_d = ST_QUERY;
					end
				end
			end
			ST_ADD: begin
				ram_we = 1'b1;
				ram_waddr = idx_q[AW-1:0];
				ram_wdata = sum;
				if (parent != '0) begin
					ram_raddr = parent[AW-1:0];
					pend_d = 1'b1;
					idx_d = parent;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_QUERY: begin
				acc_d = sum;
				if (idx_q[0]) begin
					ram_raddr = idx_q[AW-1:0];
					pend_d = 1'b1;
					idx_d = idx_q + NW'(1);
				end else if (r_q[0]) begin
					ram_raddr = r_dec[AW-1:0];
					pend_d = 1'b1;
					r_d = r_dec;
				end else begin
					idx_d = l_sh;
					r_d = r_sh;
					if (!(l_sh < r_sh)) begin
						result_d.range_sum = sum;
						result_d.range_error = 1'b0;
						result_valid_d = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			pend_q <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q <= clr_d;
			pend_q <= pend_d;
			result_valid_q <= result_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q <= idx_d;
		r_q <= r_d;
		acc_q <= acc_d;
		delta_q <= delta_d;
		result_q <= result_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result = result_q;

	a_add_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ADD |-> pend_q && idx_q != '0)
		else $error("Add walk runs without read data for its node.");

	a_query_window: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_QUERY |-> idx_q <= r_q)
		else $error("Query walk runs with its bounds crossed.");

	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> state_q == ST_IDLE)
		else $error("Result posted while the sequencer is still busy.");

	a_clear_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |=> state_q == ST_CLEAR ||
			(state_q == ST_IDLE && $past(clr_q) == AW'(DEPTH - 1)))
		else $error("Clearing pass ended before the last entry.");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the point-add, range-sum tree top level.
module tb_top;
	import stsum_pkg::*;

	localparam int MAX_POS = MAX_POSITIONS_DEF;
	localparam int RANDOM_ITEMS = 1150;
	localparam int CALM_TAIL = 150;
	localparam int SETTLE_CYCLES = 40;
	localparam int DRAIN_CYCLES = 60;
	localparam longint TIMEOUT = 64'd12 * 64'd600000;

	typedef enum bit {
		ROW_CMD,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic [SIZE_W-1:0] size;
		cmd_item_t item;
		bit fixed;
		result_item_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_item_t command = '0;
	logic result_valid;
	result_item_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [SIZE_W-1:0] cfg_data = '0;

	logic [DATA_W-1:0] leaf_value [1:MAX_POS];
	logic [SIZE_W-1:0] size_reg = SIZE_RESET;
	result_item_t pending_sums [$];
	result_item_t head_sum;
	stim_row_t stim_table [$];
	int mismatches = 0;

	segment_tree_point_add_range_sum_top #(
		.MAX_POSITIONS(MAX_POS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.command(command),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int live_size();
		return (int'(size_reg) > MAX_POS) ? MAX_POS : int'(size_reg);
	endfunction

	function automatic bit add_lands(input cmd_item_t item);
		return item.position_a >= 1 && int'(item.position_a) <= live_size();
	endfunction

	function automatic result_item_t predict_range_sum(input cmd_item_t item);
		result_item_t r;
		longint lo;
		longint hi;
		logic [DATA_W-1:0] acc;
		int p;
		lo = longint'(item.position_a);
		hi = longint'($signed(item.value_b));
		acc = '0;
		r.range_error = 1'b0;
		if (lo <= hi) begin
			if (lo < 1 || hi > longint'(live_size())) begin
				r.range_error = 1'b1;
			end else begin
				for (p = int'(lo); p <= int'(hi); p++) acc += leaf_value[p];
			end
		end
		r.range_sum = acc;
		return r;
	endfunction

	task automatic issue(input cmd_item_t item, input bit fixed, input result_item_t want);
		start <= 1'b1;
		command <= item;
		do @(posedge clk); while (busy);
		if (item.cmd == CMD_ADD) begin
			if (add_lands(item)) leaf_value[item.position_a] += item.value_b;
		end else begin
			pending_sums.push_back(fixed ? want : predict_range_sum(item));
		end
	endtask

	task automatic write_size(input logic [SIZE_W-1:0] value);
		start <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = value;
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 10);
		start <= 1'b0;
		if ($urandom_range(0, 1) == 1) begin
			while (busy) @(posedge clk);
		end
		repeat (n) @(posedge clk);
	endtask

	task automatic add_row(input row_kind_t kind, input logic [SIZE_W-1:0] size,
			input logic c, input logic [POS_W-1:0] a, input logic [DATA_W-1:0] b,
			input bit fixed, input logic [DATA_W-1:0] rs, input logic re);
		stim_row_t row;
		row.kind = kind;
		row.size = size;
		row.item.cmd = c;
		row.item.position_a = a;
		row.item.value_b = b;
		row.fixed = fixed;
		row.want.range_sum = rs;
		row.want.range_error = re;
		stim_table.push_back(row);
	endtask

	function automatic logic [DATA_W-1:0] pick_delta();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return DATA_W'($urandom_range(0, 200)) - 32'd100;
			default: return $urandom;
		endcase
	endfunction

	function automatic cmd_item_t make_item();
		cmd_item_t item;
		int eff;
		int kind;
		int a;
		eff = live_size();
		kind = $urandom_range(0, 99);
		if (eff == 0 && kind < 85) kind = 85 + $urandom_range(0, 14);
		if (kind < 45) begin
			item.cmd = CMD_ADD;
			item.position_a = POS_W'($urandom_range(1, eff));
			item.value_b = pick_delta();
		end else if (kind < 85) begin
			item.cmd = CMD_SUM;
			a = $urandom_range(1, eff);
			item.position_a = POS_W'(a);
			if ($urandom_range(0, 3) == 0) begin
				item.value_b = DATA_W'((a + $urandom_range(0, 8) > eff) ?
					eff : a + $urandom_range(0, 8));
			end else begin
				item.value_b = DATA_W'($urandom_range(a, eff));
			end
		end else begin
			item.cmd = 1'($urandom_range(0, 1));
			item.position_a = POS_W'($urandom);
			if ($urandom_range(0, 1) == 1) begin
				item.value_b = $urandom;
			end else begin
				item.value_b = DATA_W'($urandom_range(0, 8205)) - 32'd5;
			end
		end
		return item;
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 13'd1;
			1: return 13'd2;
			2: return 13'd4096;
			3: return 13'd8191;
			4: return 13'd0;
			5: return 13'd4095;
			6: return SIZE_W'($urandom_range(1, 64));
			9: return SIZE_W'($urandom_range(4097, 8191));
			default: return SIZE_W'($urandom_range(1, 4096));
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_sums.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual sum %0d error %0b",
					$time, result.range_sum, result.range_error);
				mismatches++;
			end else begin
				head_sum = pending_sums.pop_front();
				if (result.range_sum !== head_sum.range_sum) begin
					$display("%0t: range_sum mismatch, expected %0d, actual %0d",
						$time, head_sum.range_sum, result.range_sum);
					mismatches++;
				end
				if (result.range_error !== head_sum.range_error) begin
					$display("%0t: range_error mismatch, expected %0b, actual %0b",
						$time, head_sum.range_error, result.range_error);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT);
		$display("FAIL segment_tree_point_add_range_sum_top");
		$finish;
	end

	initial begin
		cmd_item_t item;
		result_item_t none;
		int landed;
		int phase_len;
		int k;
		none = '0;
		for (int i = 1; i <= MAX_POS; i++) leaf_value[i] = '0;

		add_row(ROW_CMD, 0, CMD_SUM, 1, 4096, 1, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 4096, 4096, 1, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 1, 32'h7FFF_FFFF, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 4096, 32'h8000_0000, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 1, 1, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 0, 32'h1234_5678, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 4097, 5, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 8191, 32'hFFFF_FFFF, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 1, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 4096, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 4096, 4096, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 0, 5, 1, 0, 1);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 4097, 1, 0, 1);
		add_row(ROW_CMD, 0, CMD_SUM, 5, 4, 1, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 0, 32'hFFFF_FFFF, 1, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 8191, 32'h7FFF_FFFF, 1, 0, 1);
		add_row(ROW_CMD, 0, CMD_SUM, 8191, 32'h8000_0000, 1, 0, 0);
		add_row(ROW_CFG, 1, CMD_ADD, 0, 0, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 1, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 2, 1, 0, 1);
		add_row(ROW_CMD, 0, CMD_ADD, 2, 77, 0, 0, 0);
		add_row(ROW_CFG, 0, CMD_ADD, 0, 0, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 1, 1, 0, 1);
		add_row(ROW_CMD, 0, CMD_ADD, 1, 3, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 0, 1, 0, 0);
		add_row(ROW_CFG, 8191, CMD_ADD, 0, 0, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 1, 4096, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_ADD, 2, 77, 0, 0, 0);
		add_row(ROW_CMD, 0, CMD_SUM, 2, 4096, 0, 0, 0);
		add_row(ROW_CFG, 4096, CMD_ADD, 0, 0, 0, 0, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_CFG) begin
				write_size(stim_table[i].size);
			end else begin
				issue(stim_table[i].item, stim_table[i].fixed, stim_table[i].want);
			end
		end

		landed = 0;
		while (landed < RANDOM_ITEMS) begin
			phase_len = $urandom_range(60, 160);
			write_size(pick_size());
			k = 0;
			while (k < phase_len && landed < RANDOM_ITEMS) begin
				item = make_item();
				if (landed < RANDOM_ITEMS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
					sender_gap();
				end
				if (item.cmd == CMD_SUM || add_lands(item)) begin
					landed++;
					k++;
				end
				issue(item, 1'b0, none);
			end
		end

		start <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_sums.size() != 0) begin
			$display("%0t: %0d expected sums never arrived", $time, pending_sums.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("PASS segment_tree_point_add_range_sum_top");
		end else begin
			$display("FAIL segment_tree_point_add_range_sum_top");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/stsum_pkg.sv
rtl/core/stsum_ram.sv
rtl/core/stsum_ctrl.sv
rtl/core/segment_tree_point_add_range_sum_top.sv
tb/tb_top.sv
